// ===== hw/rtl/tfn_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle face normal package
// Shared beat types and datapath widths for the face normal pipeline.
// ---------------------------------------------------------------------------
package tfn_pkg;

   localparam int EdgeW  = 17;  // vertex difference, Q4.12
   localparam int ProdW  = 34;  // edge product
   localparam int MagW   = 34;  // cross product magnitude
   localparam int NormW  = 31;  // normalised magnitude, msb at bit 30
   localparam int SqW    = 62;  // square of a normalised magnitude
   localparam int SumW   = 64;  // sum of squares
   localparam int RootW  = 32;  // integer square root
   localparam int RemW   = 34;  // square root partial remainder
   localparam int DenW   = 33;  // divisor, twice the root
   localparam int NumW   = 47;  // dividend
   localparam int QuoW   = 15;  // quotient
   localparam int PosW   = 6;   // bit position within a magnitude
   localparam int NormMsb = 30;
   localparam logic [QuoW-1:0] OneQ14 = 15'd16384;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
      logic signed [15:0] third_x;
      logic signed [15:0] third_y;
      logic signed [15:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } rsp_type;

   // Sideband that rides alongside the square root
   typedef struct packed {
      logic [2:0]            neg;
      logic                  degen;
      logic [2:0][NormW-1:0] mag;
   } norm_type;

   // Sideband that rides alongside the divider
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } sign_type;

endpackage

// ===== hw/rtl/triangle_face_normal_top.sv =====
// Each accepted request beat gives a result strobe.
// Throughput: one triangle per cycle; busy is low whenever reset is low.
// Depth is set mostly by the square root (32 stages) and the divider (16 stages).
// Reset: synchronous, active high; clears the valid bits, busy is high during it.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// Triangle face normal top level
// Unit face normal of a triangle, fully pipelined, Q3.12 in, Q1.14 out.
// ---------------------------------------------------------------------------
module triangle_face_normal_top import tfn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_payload,
   output logic     rsp_valid,
   output rsp_type  rsp_payload
);

   logic                  front_valid;
   norm_type              front_norm;
   logic [SumW-1:0]       front_sum;
   logic                  root_valid;
   norm_type              root_norm;
   logic [RootW-1:0]      root_val;
   logic                  div_valid;
   sign_type              div_sign;
   logic [2:0][QuoW-1:0]  div_quo;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [2:0][15:0]      comp_in;
   logic [QuoW-1:0]       sat_in;

   // Every beat enters the pipe; only reset holds requests off
   assign busy = reset;

   // Edges, cross product, normalising shift and sum of squares
   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_payload),
      .out_valid (front_valid),
      .out_norm  (front_norm),
      .out_sum   (front_sum)
   );

   // Length of the normalised cross product
   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_norm   (front_norm),
      .in_sum    (front_sum),
      .out_valid (root_valid),
      .out_norm  (root_norm),
      .out_root  (root_val)
   );

   // Rounded quotient of each magnitude over the length
   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_norm   (root_norm),
      .in_root   (root_val),
      .out_valid (div_valid),
      .out_sign  (div_sign),
      .out_quo   (div_quo)
   );

   // Clamp to one, apply the sign, force zero on a degenerate triangle
   always_comb begin
      sat_in = '0;
      for (int i = 0; i < 3; i++) begin
         sat_in = (div_quo[i] > OneQ14) ? OneQ14 : div_quo[i];
         if (div_sign.degen) begin
            comp_in[i] = '0;
         end else if (div_sign.neg[i]) begin
            comp_in[i] = -(16'(sat_in));
         end else begin
            comp_in[i] = 16'(sat_in);
         end
      end
      rsp_in.normal_x   = comp_in[0];
      rsp_in.normal_y   = comp_in[1];
      rsp_in.normal_z   = comp_in[2];
      rsp_in.degenerate = div_sign.degen;
   end

   // Output register: strobe for one cycle per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // every accepted beat comes out as a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##56 rsp_valid)
      else $error("face normal result missing after accepted beat");

   // a degenerate triangle gives the zero vector
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.degenerate) |->
      (rsp_payload.normal_x == 16'sd0 && rsp_payload.normal_y == 16'sd0 &&
       rsp_payload.normal_z == 16'sd0))
      else $error("degenerate face normal is not zero");

   // components stay within one in magnitude
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_payload.normal_x <= 16'sd16384 && rsp_payload.normal_x >= -16'sd16384 &&
       rsp_payload.normal_y <= 16'sd16384 && rsp_payload.normal_y >= -16'sd16384 &&
       rsp_payload.normal_z <= 16'sd16384 && rsp_payload.normal_z >= -16'sd16384))
      else $error("face normal component out of range");
`endif

endmodule

// ===== hw/rtl/tfn_front.sv =====
// ---------------------------------------------------------------------------
// Face normal front end
// Edges, cross product, magnitudes, normalising shift and sum of squares.
// ---------------------------------------------------------------------------
module tfn_front import tfn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  req_type             in_data,
   output logic                out_valid,
   output norm_type            out_norm,
   output logic [SumW-1:0]     out_sum
);

   logic [6:0] valid_ff;

   // edges
   logic signed [EdgeW-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   // products
   logic signed [ProdW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   // magnitudes
   logic [2:0][MagW-1:0]    mag_ff;
   logic [2:0]              neg3_ff, neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [2:0][MagW-1:0]    mag4_ff;
   logic [PosW-1:0]         pos_ff;
   logic                    degen4_ff, degen5_ff, degen6_ff, degen7_ff;
   logic [2:0][NormW-1:0]   nmag_ff, nmag6_ff, nmag7_ff;
   logic [2:0][SqW-1:0]     sq_ff;
   logic [SumW-1:0]         sum_ff;

   logic signed [ProdW:0]   c_in [3];
   logic [2:0][MagW-1:0]    mag_in;
   logic [2:0]              neg_in;
   logic [MagW-1:0]         any_in;
   logic [PosW-1:0]         pos_in;
   logic [2:0][NormW-1:0]   nmag_in;
   logic [PosW-1:0]         lsh_in, rsh_in;
   logic [63:0]             wide_in;

   always_comb begin
      c_in[0] = (ProdW+1)'(p0_ff) - (ProdW+1)'(p1_ff);
      c_in[1] = (ProdW+1)'(p2_ff) - (ProdW+1)'(p3_ff);
      c_in[2] = (ProdW+1)'(p4_ff) - (ProdW+1)'(p5_ff);
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = c_in[i][ProdW];
         mag_in[i] = neg_in[i] ? MagW'(-c_in[i]) : MagW'(c_in[i]);
      end
   end

   // highest set bit of the largest magnitude
   always_comb begin
      any_in = mag_ff[0] | mag_ff[1] | mag_ff[2];
      pos_in = '0;
      for (int i = 0; i < MagW; i++) begin
         if (any_in[i]) pos_in = PosW'(i);
      end
   end

   always_comb begin
      lsh_in = PosW'(NormMsb) - pos_ff;
      rsh_in = pos_ff - PosW'(NormMsb);
      wide_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= PosW'(NormMsb)) begin
            nmag_in[i] = NormW'(mag4_ff[i] >> rsh_in);
         end else begin
            wide_in = 64'(mag4_ff[i]) << lsh_in;
            nmag_in[i] = wide_in[NormW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= EdgeW'(in_data.third_x) - EdgeW'(in_data.first_x);
      ay_ff <= EdgeW'(in_data.third_y) - EdgeW'(in_data.first_y);
      az_ff <= EdgeW'(in_data.third_z) - EdgeW'(in_data.first_z);
      bx_ff <= EdgeW'(in_data.second_x) - EdgeW'(in_data.first_x);
      by_ff <= EdgeW'(in_data.second_y) - EdgeW'(in_data.first_y);
      bz_ff <= EdgeW'(in_data.second_z) - EdgeW'(in_data.first_z);

      p0_ff <= ay_ff * bz_ff;
      p1_ff <= az_ff * by_ff;
      p2_ff <= az_ff * bx_ff;
      p3_ff <= ax_ff * bz_ff;
      p4_ff <= ax_ff * by_ff;
      p5_ff <= ay_ff * bx_ff;

      mag_ff  <= mag_in;
      neg3_ff <= neg_in;

      mag4_ff   <= mag_ff;
      pos_ff    <= pos_in;
      degen4_ff <= (any_in == '0);
      neg4_ff   <= neg3_ff;

      nmag_ff   <= nmag_in;
      degen5_ff <= degen4_ff;
      neg5_ff   <= neg4_ff;

      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SqW'(nmag_ff[i]) * SqW'(nmag_ff[i]);
      end
      nmag6_ff  <= nmag_ff;
      degen6_ff <= degen5_ff;
      neg6_ff   <= neg5_ff;

      sum_ff    <= SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
      nmag7_ff  <= nmag6_ff;
      degen7_ff <= degen6_ff;
      neg7_ff   <= neg6_ff;
   end

   assign out_valid      = valid_ff[6];
   assign out_sum        = sum_ff;
   assign out_norm.neg   = neg7_ff;
   assign out_norm.degen = degen7_ff;
   assign out_norm.mag   = nmag7_ff;

endmodule

// ===== hw/rtl/tfn_sqrt.sv =====
// ---------------------------------------------------------------------------
// Face normal square root
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  norm_type          in_norm,
   input  logic [SumW-1:0]   in_sum,
   output logic              out_valid,
   output norm_type          out_norm,
   output logic [RootW-1:0]  out_root
);

   logic                valid_ff [RootW];
   logic [RemW-1:0]     rem_ff   [RootW];
   logic [RootW-1:0]    root_ff  [RootW];
   logic [SumW-1:0]     rad_ff   [RootW];
   norm_type            side_ff  [RootW];

   for (genvar i = 0; i < RootW; i++) begin : g_step
      logic             valid_cur;
      logic [RemW-1:0]  rem_cur;
      logic [RootW-1:0] root_cur;
      logic [SumW-1:0]  rad_cur;
      norm_type         side_cur;
      logic [RemW+1:0]  trial_in, test_in;
      logic             take_in;

      if (i == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign rad_cur   = in_sum;
         assign side_cur  = in_norm;
      end else begin : g_next
         assign valid_cur = valid_ff[i-1];
         assign rem_cur   = rem_ff[i-1];
         assign root_cur  = root_ff[i-1];
         assign rad_cur   = rad_ff[i-1];
         assign side_cur  = side_ff[i-1];
      end

      assign trial_in = {rem_cur, rad_cur[SumW-1 -: 2]};
      assign test_in  = {root_cur, 2'b01};
      assign take_in  = (trial_in >= test_in);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= take_in ? RemW'(trial_in - test_in) : RemW'(trial_in);
         root_ff[i] <= {root_cur[RootW-2:0], take_in};
         rad_ff[i]  <= {rad_cur[SumW-3:0], 2'b00};
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = valid_ff[RootW-1];
   assign out_norm  = side_ff[RootW-1];
   assign out_root  = root_ff[RootW-1];

endmodule

// ===== hw/rtl/tfn_div.sv =====
// ---------------------------------------------------------------------------
// Face normal divider
// Three pipelined restoring dividers, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  norm_type              in_norm,
   input  logic [RootW-1:0]      in_root,
   output logic                  out_valid,
   output sign_type              out_sign,
   output logic [2:0][QuoW-1:0]  out_quo
);

   localparam int Steps = QuoW + 1;

   logic                  valid_ff [Steps];
   logic [2:0][NumW-1:0]  num_ff   [Steps];
   logic [2:0][QuoW-1:0]  quo_ff   [Steps];
   logic [DenW-1:0]       den_ff   [Steps];
   sign_type              sign_ff  [Steps];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   // dividend is the magnitude scaled by 2^15 plus the root, for rounding
   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         num_ff[0][l] <= (NumW'(in_norm.mag[l]) << (QuoW)) + NumW'(in_root);
      end
      quo_ff[0]        <= '0;
      den_ff[0]        <= {in_root, 1'b0};
      sign_ff[0].neg   <= in_norm.neg;
      sign_ff[0].degen <= in_norm.degen;
   end

   for (genvar j = 0; j < QuoW; j++) begin : g_step
      localparam int Sh = QuoW - 1 - j;
      logic [NumW:0]         dsh_in;
      logic [2:0][NumW-1:0]  num_in;
      logic [2:0][QuoW-1:0]  quo_in;

      always_comb begin
         dsh_in = (NumW+1)'(den_ff[j]) << Sh;
         for (int l = 0; l < 3; l++) begin
            quo_in[l] = quo_ff[j][l];
            num_in[l] = num_ff[j][l];
            if ({1'b0, num_ff[j][l]} >= dsh_in) begin
               num_in[l]     = NumW'({1'b0, num_ff[j][l]} - dsh_in);
               quo_in[l][Sh] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         num_ff[j+1]  <= num_in;
         quo_ff[j+1]  <= quo_in;
         den_ff[j+1]  <= den_ff[j];
         sign_ff[j+1] <= sign_ff[j];
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_sign  = sign_ff[Steps-1];
   assign out_quo   = quo_ff[Steps-1];

endmodule
